/* design/kthg_pkg.sv */
`default_nettype none

package kthg_pkg;

  localparam logic [7:0] KEY_NUL  = 8'h00;
  localparam logic [7:0] KEY_LF   = 8'h0A;
  localparam logic [7:0] KEY_CR   = 8'h0D;
  localparam logic [7:0] KEY_0    = 8'h30;
  localparam logic [7:0] KEY_9    = 8'h39;
  localparam logic [7:0] KEY_HASH = 8'h23;
  localparam logic [7:0] KEY_STAR = 8'h2A;
  localparam logic [7:0] KEY_A    = 8'h41;
  localparam logic [7:0] KEY_B    = 8'h42;
  localparam logic [7:0] KEY_C    = 8'h43;
  localparam logic [7:0] KEY_D    = 8'h44;
  localparam logic [7:0] KEY_DASH = 8'h2D;

  localparam logic [9:0] STEP_CM      = 10'd5;
  localparam logic [9:0] FLOOR_RST    = 10'd5;
  localparam logic [9:0] CEILING_RST  = 10'd400;
  localparam logic [9:0] DEFAULT_RST  = 10'd20;
  localparam logic [7:0] HYST_RST     = 8'd5;
  localparam logic [13:0] HALF_CM_RAW = 14'd8;

  typedef enum logic [1:0] {
    REG_FLOOR   = 2'd0,
    REG_CEILING = 2'd1,
    REG_DEFAULT = 2'd2,
    REG_HYST    = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [9:0] floor_cm;
    logic [9:0] ceiling_cm;
    logic [9:0] default_cm;
    logic [7:0] hyst_cm;
  } cfg_t;

  typedef struct packed {
    logic go;
    logic is_sample;
  } step_t;

endpackage

`default_nettype wire

/* design/keypad_threshold_hysteresis_gate.sv */
`default_nettype none

// Channel  Signals                                       Word
// in       in_valid, in_stall, action/key_code/raw_dist.  one key or distance sample
// out      out_valid, out_stall, gate_open .. last_key    state after that word
// cfg      cfg_write, cfg_index, cfg_data                 one register write
//
// One word per cycle sustained while out_stall is low.
// The input register and the state registers form the two stages; the state
// registers drive the result ports directly, apart from the saturating entry_value and entry_count.
// Reset (rst, synchronous) loads register defaults, closes the gate, threshold 20.
// A stalled result holds the state; one more word waits in the input register.

module keypad_threshold_hysteresis_gate #(
  parameter int ENTRY_DIGITS = 3
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [9:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        action,
  input  wire logic [7:0]  key_code,
  input  wire logic [13:0] raw_distance,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             gate_open,
  output logic             sensor_valid,
  output logic [9:0]       distance_cm,
  output logic [9:0]       threshold_cm,
  output logic [1:0]       entry_count,
  output logic [9:0]       entry_value
  ,output logic [7:0]      last_key
);
  import kthg_pkg::*;

  localparam int ACC_W = $clog2(10 ** ENTRY_DIGITS);
  localparam int CNT_W = $clog2(ENTRY_DIGITS + 1);
  localparam int ACC_EXT_W = (ACC_W > 10) ? ACC_W : 10;
  localparam int CNT_EXT_W = (CNT_W > 2) ? CNT_W : 2;

  cfg_t             cfg;
  logic             s1_valid;
  logic             s1_action;
  logic [7:0]       s1_key;
  logic [13:0]      s1_raw;
  logic             advance;
  logic             load;
  step_t            step;
  logic [ACC_W-1:0] acc;
  logic [CNT_W-1:0] count;
  logic [ACC_EXT_W-1:0] acc_ext;
  logic [CNT_EXT_W-1:0] count_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.floor_cm   <= FLOOR_RST;
      cfg.ceiling_cm <= CEILING_RST;
      cfg.default_cm <= DEFAULT_RST;
      cfg.hyst_cm    <= HYST_RST;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FLOOR:   cfg.floor_cm   <= cfg_data;
        REG_CEILING: cfg.ceiling_cm <= cfg_data;
        REG_DEFAULT: cfg.default_cm <= cfg_data;
        REG_HYST:    cfg.hyst_cm    <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_action <= action;
      s1_key    <= key_code;
      s1_raw    <= raw_distance;
    end
  end

  assign step.go        = advance;
  assign step.is_sample = s1_action;

  kthg_keypad #(
    .ENTRY_DIGITS(ENTRY_DIGITS),
    .ACC_W(ACC_W),
    .CNT_W(CNT_W)
  ) u_keypad (
    .clk(clk),
    .rst(rst),
    .step(step),
    .key(s1_key),
    .cfg(cfg),
    .threshold(threshold_cm),
    .acc(acc),
    .count(count),
    .recent_key(last_key)
  );

  kthg_ranger u_ranger (
    .clk(clk),
    .rst(rst),
    .step(step),
    .raw(s1_raw),
    .threshold(threshold_cm),
    .cfg(cfg),
    .gate(gate_open),
    .valid_flag(sensor_valid),
    .last_distance(distance_cm)
  );

  assign acc_ext     = ACC_EXT_W'(acc);
  assign count_ext   = CNT_EXT_W'(count);
  assign entry_value = (acc_ext > ACC_EXT_W'(1023)) ? 10'd1023 : acc_ext[9:0];
  assign entry_count = (count_ext > CNT_EXT_W'(3)) ? 2'd3 : count_ext[1:0];

  a_gate_needs_valid: assert property (@(posedge clk) disable iff (rst)
    gate_open |-> sensor_valid)
    else $error("gate open without a valid sample");

  a_distance_matches_valid: assert property (@(posedge clk) disable iff (rst)
    sensor_valid == (distance_cm != 10'd0))
    else $error("distance and valid flag disagree");

  a_empty_entry_zero: assert property (@(posedge clk) disable iff (rst)
    (entry_count == 2'd0) |-> (entry_value == 10'd0))
    else $error("empty entry holds a value");

  a_word_captured: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> s1_valid)
    else $error("accepted word not held in input register");

endmodule

`default_nettype wire

/* design/kthg_keypad.sv */
`default_nettype none

module kthg_keypad #(
  parameter int ENTRY_DIGITS = 3,
  parameter int ACC_W = $clog2(10 ** ENTRY_DIGITS),
  parameter int CNT_W = $clog2(ENTRY_DIGITS + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire kthg_pkg::step_t    step,
  input  wire logic [7:0]         key,
  input  wire kthg_pkg::cfg_t     cfg,
  output logic [9:0]              threshold,
  output logic [ACC_W-1:0]        acc,
  output logic [CNT_W-1:0]        count,
  output logic [7:0]              recent_key
);
  import kthg_pkg::*;

  localparam int EXT_W = (ACC_W > 11) ? ACC_W : 11;

  logic [9:0]       threshold_next;
  logic [ACC_W-1:0] acc_next;
  logic [CNT_W-1:0] count_next;
  logic [7:0]       recent_key_next;

  function automatic logic [9:0] clamp_thr(input logic [EXT_W-1:0] v,
                                           input logic [9:0] lo,
                                           input logic [9:0] hi);
    logic [9:0] r;
    if (v < EXT_W'(lo)) begin
      r = lo;
    end else if (v > EXT_W'(hi)) begin
      r = hi;
    end else begin
      r = v[9:0];
    end
    return r;
  endfunction

  always_comb begin
    threshold_next  = threshold;
    acc_next        = acc;
    count_next      = count;
    recent_key_next = recent_key;
    if (step.go && !step.is_sample) begin
      unique case (key) inside
        KEY_NUL, KEY_LF, KEY_CR: begin
        end
        [KEY_0:KEY_9]: begin
          recent_key_next = key;
          if (count < CNT_W'(ENTRY_DIGITS)) begin
            acc_next   = ACC_W'(acc * ACC_W'(10)) + ACC_W'(key - KEY_0);
            count_next = count + CNT_W'(1);
          end
        end
        KEY_HASH, KEY_A: begin
          recent_key_next = key;
          if (count != '0) begin
            threshold_next = clamp_thr(EXT_W'(acc), cfg.floor_cm, cfg.ceiling_cm);
            acc_next       = '0;
            count_next     = '0;
          end
        end
        KEY_STAR, KEY_B: begin
          recent_key_next = key;
          acc_next        = '0;
          count_next      = '0;
        end
        KEY_C: begin
          recent_key_next = key;
          threshold_next  = cfg.default_cm;
          acc_next        = '0;
          count_next      = '0;
        end
        KEY_D: begin
          recent_key_next = key;
          threshold_next  = clamp_thr(EXT_W'(threshold) + EXT_W'(STEP_CM),
                                      cfg.floor_cm, cfg.ceiling_cm);
          acc_next        = '0;
          count_next      = '0;
        end
        default: begin
          recent_key_next = key;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold  <= DEFAULT_RST;
      acc        <= '0;
      count      <= '0;
      recent_key <= KEY_DASH;
    end else begin
      threshold  <= threshold_next;
      acc        <= acc_next;
      count      <= count_next;
      recent_key <= recent_key_next;
    end
  end

endmodule

`default_nettype wire

/* design/kthg_ranger.sv */
`default_nettype none

module kthg_ranger (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire kthg_pkg::step_t   step,
  input  wire logic [13:0]       raw,
  input  wire logic [9:0]        threshold,
  input  wire kthg_pkg::cfg_t    cfg,
  output logic                   gate,
  output logic                   valid_flag,
  output logic [9:0]             last_distance
);
  import kthg_pkg::*;

  logic        in_range;
  logic [14:0] rounded;
  logic [9:0]  sample_cm;
  logic [10:0] close_lim;
  logic        gate_next;
  logic        valid_flag_next;
  logic [9:0]  last_distance_next;

  always_comb begin
    in_range  = (raw > HALF_CM_RAW) && (raw <= {cfg.ceiling_cm, 4'b0000});
    rounded   = 15'(raw) + 15'(HALF_CM_RAW);
    sample_cm = in_range ? rounded[13:4] : 10'd0;
    close_lim = 11'(threshold) + 11'(cfg.hyst_cm);

    gate_next          = gate;
    valid_flag_next    = valid_flag;
    last_distance_next = last_distance;
    if (step.go && step.is_sample) begin
      valid_flag_next    = in_range;
      last_distance_next = sample_cm;
      if (!in_range) begin
        gate_next = 1'b0;
      end else if (!gate && (sample_cm < threshold)) begin
        gate_next = 1'b1;
      end else if (gate && (11'(sample_cm) > close_lim)) begin
        gate_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gate          <= 1'b0;
      valid_flag    <= 1'b0;
      last_distance <= '0;
    end else begin
      gate          <= gate_next;
      valid_flag    <= valid_flag_next;
      last_distance <= last_distance_next;
    end
  end

endmodule

`default_nettype wire
